// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clock; TSP_ASSERT is disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define TSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define TSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// types and constants of the time string parser
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned NUM_W   = 7;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned TIME_W  = 25;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_P = 8'h70;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [NUM_W-1:0] HOUR_NOON  = 7'd12;
   localparam logic [NUM_W-1:0] HOUR_MAX   = 7'd23;
   localparam logic [NUM_W-1:0] MINSEC_MAX = 7'd59;
   localparam logic [NUM_W-1:0] TEN        = 7'd10;

   localparam logic [TIME_W-1:0] HOUR_SCALE   = 25'd1000000;
   localparam logic [TIME_W-1:0] MINUTE_SCALE = 25'd10000;
   localparam logic [TIME_W-1:0] SECOND_SCALE = 25'd100;

   typedef enum logic [2:0] {
      PHASE_HOUR   = 3'd0,
      PHASE_MINUTE = 3'd1,
      PHASE_SECOND = 3'd2,
      PHASE_CENTI  = 3'd3,
      PHASE_ALLOW  = 3'd4,
      PHASE_DONE   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_REPEAT = 2'd2,
      STATUS_RANGE  = 2'd3
   } status_type;

   typedef struct packed {
      phase_type              phase;
      logic                   pend_valid;
      logic [DIGIT_W-1:0]     pend_digit;
      logic [NUM_W-1:0]       hour;
      logic [NUM_W-1:0]       minute;
      logic [NUM_W-1:0]       second;
      logic [NUM_W-1:0]       centi;
      logic                   seen_am;
      logic                   seen_pm;
      status_type             err;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:      PHASE_HOUR,
      pend_valid: 1'b0,
      pend_digit: '0,
      hour:       '0,
      minute:     '0,
      second:     '0,
      centi:      '0,
      seen_am:    1'b0,
      seen_pm:    1'b0,
      err:        STATUS_OK
   };

endpackage

`default_nettype wire

// ===== sv/tsp_if.sv =====
// ----------------------------------------------------------------------------
// tsp_if
// valid/ready channels carrying character words and time result words
// ----------------------------------------------------------------------------
`default_nettype none

interface tsp_req_if;
   logic                        valid;
   logic                        ready;
   logic [tsp_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface tsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tsp_pkg::TIME_W-1:0]  time_value;
   logic [1:0]                  status;

   modport source (output valid, output time_value, output status, input ready);
   modport sink   (input valid, input time_value, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/tsp_parse.sv =====
// ----------------------------------------------------------------------------
// tsp_parse
// parser state register and per-character next-state logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsp_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_valid,
   input  wire logic [tsp_pkg::CHAR_W-1:0]  char_code,
   output tsp_pkg::state_type               final_state
);

   tsp_pkg::state_type state_ff;
   tsp_pkg::state_type state_in;

   function automatic tsp_pkg::state_type take_number(
      input tsp_pkg::state_type s,
      input logic [tsp_pkg::NUM_W-1:0] num
   );
      tsp_pkg::state_type r;
      r = s;
      if (s.err == tsp_pkg::STATUS_OK) begin
         case (s.phase)
            tsp_pkg::PHASE_HOUR: begin
               r.hour  = num;
               r.phase = tsp_pkg::PHASE_MINUTE;
            end
            tsp_pkg::PHASE_MINUTE: begin
               r.minute = num;
               r.phase  = tsp_pkg::PHASE_SECOND;
            end
            tsp_pkg::PHASE_SECOND: begin
               r.second = num;
               r.phase  = tsp_pkg::PHASE_CENTI;
            end
            tsp_pkg::PHASE_CENTI: begin
               r.centi = num;
               r.phase = tsp_pkg::PHASE_ALLOW;
            end
            default: begin
               r.err = tsp_pkg::STATUS_FORMAT;
            end
         endcase
      end
      return r;
   endfunction

   function automatic tsp_pkg::state_type take_marker(
      input tsp_pkg::state_type s,
      input logic is_pm
   );
      tsp_pkg::state_type r;
      r = s;
      if (s.err == tsp_pkg::STATUS_OK) begin
         if (s.phase == tsp_pkg::PHASE_DONE) begin
            r.err = tsp_pkg::STATUS_FORMAT;
         end else if (s.seen_am || s.seen_pm) begin
            r.err = tsp_pkg::STATUS_REPEAT;
         end else begin
            r.seen_pm = is_pm;
            r.seen_am = !is_pm;
            if (s.phase == tsp_pkg::PHASE_ALLOW) begin
               r.phase = tsp_pkg::PHASE_DONE;
            end
         end
      end
      return r;
   endfunction

   logic                          is_term;
   logic                          is_digit;
   logic [tsp_pkg::CHAR_W-1:0]    lower_char;
   logic [tsp_pkg::CHAR_W-1:0]    digit_full;
   logic [tsp_pkg::DIGIT_W-1:0]   digit;
   logic [tsp_pkg::NUM_W-1:0]     pair_value;

   assign is_term    = (char_code == tsp_pkg::CHAR_NUL);
   assign is_digit   = (char_code >= tsp_pkg::CHAR_ZERO) && (char_code <= tsp_pkg::CHAR_NINE);
   assign lower_char = ((char_code >= tsp_pkg::CHAR_UPPER_A) &&
                        (char_code <= tsp_pkg::CHAR_UPPER_Z)) ?
                       (char_code + tsp_pkg::CASE_OFFSET) : char_code;
   assign digit_full = char_code - tsp_pkg::CHAR_ZERO;
   assign digit      = digit_full[tsp_pkg::DIGIT_W-1:0];
   // tens digit times ten plus units digit
   assign pair_value = {state_ff.pend_digit, 3'b000} + {2'b00, state_ff.pend_digit, 1'b0} +
                       {3'b000, digit};

   always_comb begin
      tsp_pkg::state_type s;
      s           = state_ff;
      final_state = state_ff;
      if ((state_ff.err != tsp_pkg::STATUS_OK) && !is_term) begin
         s.pend_valid = 1'b0;
      end else if (is_digit) begin
         if (state_ff.pend_valid) begin
            s.pend_valid = 1'b0;
            s = take_number(s, pair_value);
         end else begin
            s.pend_digit = digit;
            s.pend_valid = 1'b1;
         end
      end else begin
         // a lone pending digit completes as a one-digit number
         if (state_ff.pend_valid) begin
            s.pend_valid = 1'b0;
            s = take_number(s, {3'b000, state_ff.pend_digit});
         end
         final_state = s;
         if (is_term) begin
            s = tsp_pkg::STATE_RESET;
         end else if (lower_char == tsp_pkg::CHAR_LOWER_A) begin
            s = take_marker(s, 1'b0);
         end else if (lower_char == tsp_pkg::CHAR_LOWER_P) begin
            s = take_marker(s, 1'b1);
         end
      end
      state_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_pkg::STATE_RESET;
      end else if (step_valid) begin
         state_ff <= state_in;
      end
   end

   `TSP_ASSERT(a_term_clears_state,
      step_valid && (char_code == tsp_pkg::CHAR_NUL) |=> state_ff == tsp_pkg::STATE_RESET,
      "parser state not cleared after terminator")
   `TSP_ASSERT(a_error_drops_pending,
      (state_ff.err != tsp_pkg::STATUS_OK) && $past(state_ff.err != tsp_pkg::STATUS_OK) &&
      $past(step_valid) |-> !state_ff.pend_valid,
      "pending digit kept while in error")

endmodule

`default_nettype wire

// ===== sv/tsp_finish.sv =====
// ----------------------------------------------------------------------------
// tsp_finish
// 12-hour adjustment, range check and HHMMSScc packing at the terminator
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_finish (
   input  wire tsp_pkg::state_type           final_state,
   output logic [tsp_pkg::TIME_W-1:0]        time_value,
   output tsp_pkg::status_type               status
);

   logic [tsp_pkg::NUM_W-1:0]  hour_adj;
   logic                       out_of_range;
   logic [tsp_pkg::TIME_W-1:0] packed_time;

   always_comb begin
      hour_adj = final_state.hour;
      if (final_state.seen_pm && (final_state.hour < tsp_pkg::HOUR_NOON)) begin
         hour_adj = final_state.hour + tsp_pkg::HOUR_NOON;
      end else if (final_state.seen_am && (final_state.hour == tsp_pkg::HOUR_NOON)) begin
         hour_adj = '0;
      end
   end

   assign out_of_range = (hour_adj > tsp_pkg::HOUR_MAX) ||
                         (final_state.minute > tsp_pkg::MINSEC_MAX) ||
                         (final_state.second > tsp_pkg::MINSEC_MAX);

   assign packed_time = ({18'd0, hour_adj} * tsp_pkg::HOUR_SCALE) +
                        ({18'd0, final_state.minute} * tsp_pkg::MINUTE_SCALE) +
                        ({18'd0, final_state.second} * tsp_pkg::SECOND_SCALE) +
                        {18'd0, final_state.centi};

   always_comb begin
      if (final_state.err != tsp_pkg::STATUS_OK) begin
         status     = final_state.err;
         time_value = '0;
      end else if (out_of_range) begin
         status     = tsp_pkg::STATUS_RANGE;
         time_value = '0;
      end else begin
         status     = tsp_pkg::STATUS_OK;
         time_value = packed_time;
      end
   end

endmodule

`default_nettype wire

// ===== sv/time_string_parser_core.sv =====
// ----------------------------------------------------------------------------
// time_string_parser_core
// streaming parser of time strings into HHMMSScc with status
//
// req_ch carries one character word per handshake; a zero byte ends the
// string. rsp_ch carries one result word per terminator: time_value and
// status. Non-terminator characters produce no result.
// Each accepted character waits in the input register, from which the
// parser state is updated as it advances; a terminator loads the result
// register as it advances, and rsp_ch offers the result from there.
// Throughput is one character per cycle; the only limit is the single
// result register, which a terminator needs free (or being drained).
// When rsp_ch stalls, ordinary characters keep flowing; a terminator
// waits in the input register and req_ch.ready drops until the result
// is taken. Reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module time_string_parser_core (
   input  wire logic   clock,
   input  wire logic   reset,
   tsp_req_if.sink     req_ch,
   tsp_rsp_if.source   rsp_ch
);

   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [tsp_pkg::CHAR_W-1:0]   in_char_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [tsp_pkg::TIME_W-1:0]   out_time_ff;
   tsp_pkg::status_type          out_status_ff;

   logic                         in_term;
   logic                         advance;
   logic                         load_result;
   tsp_pkg::state_type           final_state;
   logic [tsp_pkg::TIME_W-1:0]   fin_time;
   tsp_pkg::status_type          fin_status;

   assign in_term     = (in_char_ff == tsp_pkg::CHAR_NUL);
   assign advance     = in_valid_ff && (!in_term || !out_valid_ff || rsp_ch.ready);
   assign load_result = advance && in_term;

   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !advance);
   assign out_valid_in = load_result || (out_valid_ff && !rsp_ch.ready);

   tsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .char_code   (in_char_ff),
      .final_state (final_state)
   );

   tsp_finish u_finish (
      .final_state (final_state),
      .time_value  (fin_time),
      .status      (fin_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_char_ff <= req_ch.char_code;
      end
      if (load_result) begin
         out_time_ff   <= fin_time;
         out_status_ff <= fin_status;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.time_value = out_time_ff;
   assign rsp_ch.status     = out_status_ff;

   `TSP_ASSERT(a_result_from_term,
      $rose(out_valid_ff) |-> $past(load_result),
      "result word without a terminator")
   `TSP_ASSERT(a_error_zero_time,
      out_valid_ff && (out_status_ff != tsp_pkg::STATUS_OK) |-> out_time_ff == '0,
      "nonzero time with error status")
   `TSP_ASSERT(a_term_waits,
      in_valid_ff && in_term && out_valid_ff && !rsp_ch.ready |=>
         in_valid_ff && in_term && out_valid_ff,
      "terminator lost while result register full")

endmodule

`default_nettype wire

// ===== verif/time_string_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// time_string_parser_core_tb
// self-checking bench for the streaming time string parser
//
// Character words go in through req_ch from a backlog queue. Every accepted
// word is run through a bench-side copy of the parser, which queues the time
// word that each terminator should produce. A monitor on rsp_ch checks each
// time word, field by field, against the oldest queued prediction. Stimulus is
// a few hand-written strings, then random strings: mostly well-formed times
// with random delimiters and am/pm markers, some with too many numbers or
// markers, and some raw byte noise. Both channels idle at random; the result
// side also holds off for a long stretch while characters keep coming.
// ----------------------------------------------------------------------------
`default_nettype none

module time_string_parser_core_tb;

   typedef logic [tsp_pkg::CHAR_W-1:0]  char_type;
   typedef logic [tsp_pkg::NUM_W-1:0]   num_type;
   typedef logic [tsp_pkg::DIGIT_W-1:0] digit_type;
   typedef logic [tsp_pkg::TIME_W-1:0]  time_bits_type;

   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned IDLE_PCT     = 34;

   localparam char_type CHAR_LOWER_M = "m";
   localparam char_type CHAR_COLON   = ":";
   localparam char_type CHAR_DOT     = ".";
   localparam char_type CHAR_SPACE   = " ";
   localparam char_type CHAR_DASH    = "-";

   typedef struct {
      time_bits_type       time_value;
      tsp_pkg::status_type status;
   } time_word_type;

   logic clock;
   logic reset;

   tsp_req_if req_ch ();
   tsp_rsp_if rsp_ch ();

   time_string_parser_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   char_type      char_backlog[$];
   time_word_type time_expect[$];

   int unsigned   idle_pct = IDLE_PCT;
   bit            hold_armed = 1'b0;
   bit            hold_taken = 1'b0;
   int unsigned   hold_left = 0;
   int unsigned   chars_taken = 0;
   int unsigned   words_checked = 0;
   int unsigned   fail_count = 0;
   int unsigned   status_seen[4] = '{default: 0};
   time_word_type got_word;
   time_word_type want_word;

   // parser copy
   tsp_pkg::phase_type  cur_phase;
   bit                  pend_ok;
   digit_type           pend_digit;
   num_type             hour_v;
   num_type             minute_v;
   num_type             second_v;
   num_type             centi_v;
   bit                  am_seen;
   bit                  pm_seen;
   tsp_pkg::status_type cur_err;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic clear_parser();
      cur_phase  = tsp_pkg::PHASE_HOUR;
      pend_ok    = 1'b0;
      pend_digit = '0;
      hour_v     = '0;
      minute_v   = '0;
      second_v   = '0;
      centi_v    = '0;
      am_seen    = 1'b0;
      pm_seen    = 1'b0;
      cur_err    = tsp_pkg::STATUS_OK;
   endtask

   task automatic store_number(input int num);
      if (cur_err != tsp_pkg::STATUS_OK) return;
      case (cur_phase)
         tsp_pkg::PHASE_HOUR: begin
            hour_v = num_type'(num);
            cur_phase = tsp_pkg::PHASE_MINUTE;
         end
         tsp_pkg::PHASE_MINUTE: begin
            minute_v = num_type'(num);
            cur_phase = tsp_pkg::PHASE_SECOND;
         end
         tsp_pkg::PHASE_SECOND: begin
            second_v = num_type'(num);
            cur_phase = tsp_pkg::PHASE_CENTI;
         end
         tsp_pkg::PHASE_CENTI: begin
            centi_v = num_type'(num);
            cur_phase = tsp_pkg::PHASE_ALLOW;
         end
         default: cur_err = tsp_pkg::STATUS_FORMAT;
      endcase
   endtask

   task automatic advance_parser(input char_type ch);
      char_type      c;
      bit            is_digit;
      int            h;
      time_word_type word;
      is_digit = (ch >= tsp_pkg::CHAR_ZERO) && (ch <= tsp_pkg::CHAR_NINE);
      c = ch;
      if (c >= tsp_pkg::CHAR_UPPER_A && c <= tsp_pkg::CHAR_UPPER_Z)
         c = c + tsp_pkg::CASE_OFFSET;
      if (cur_err != tsp_pkg::STATUS_OK && c != tsp_pkg::CHAR_NUL) begin
         pend_ok = 1'b0;
         return;
      end
      if (is_digit) begin
         if (pend_ok) begin
            pend_ok = 1'b0;
            store_number(int'(pend_digit) * 10 + int'(c - tsp_pkg::CHAR_ZERO));
         end else begin
            pend_digit = digit_type'(c - tsp_pkg::CHAR_ZERO);
            pend_ok = 1'b1;
         end
         return;
      end
      if (pend_ok) begin
         pend_ok = 1'b0;
         store_number(int'(pend_digit));
      end
      if (c == tsp_pkg::CHAR_NUL) begin
         word.time_value = '0;
         if (cur_err == tsp_pkg::STATUS_OK) begin
            h = int'(hour_v);
            // 12-hour adjustment
            if (pm_seen && h < int'(tsp_pkg::HOUR_NOON)) h = h + int'(tsp_pkg::HOUR_NOON);
            else if (am_seen && h == int'(tsp_pkg::HOUR_NOON)) h = 0;
            if (h > int'(tsp_pkg::HOUR_MAX) || minute_v > tsp_pkg::MINSEC_MAX
                || second_v > tsp_pkg::MINSEC_MAX) begin
               cur_err = tsp_pkg::STATUS_RANGE;
            end else begin
               word.time_value = time_bits_type'(h) * tsp_pkg::HOUR_SCALE
                               + time_bits_type'(minute_v) * tsp_pkg::MINUTE_SCALE
                               + time_bits_type'(second_v) * tsp_pkg::SECOND_SCALE
                               + time_bits_type'(centi_v);
            end
         end
         word.status = cur_err;
         time_expect.push_back(word);
         clear_parser();
      end else if (c == tsp_pkg::CHAR_LOWER_A || c == tsp_pkg::CHAR_LOWER_P) begin
         if (cur_phase == tsp_pkg::PHASE_DONE) begin
            cur_err = tsp_pkg::STATUS_FORMAT;
         end else if (am_seen || pm_seen) begin
            cur_err = tsp_pkg::STATUS_REPEAT;
         end else begin
            pm_seen = (c == tsp_pkg::CHAR_LOWER_P);
            am_seen = (c == tsp_pkg::CHAR_LOWER_A);
            if (cur_phase == tsp_pkg::PHASE_ALLOW) cur_phase = tsp_pkg::PHASE_DONE;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.char_code <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            advance_parser(req_ch.char_code);
            void'(char_backlog.pop_front());
            chars_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (char_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.char_code <= char_backlog[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result side ready, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_taken) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_word.time_value = rsp_ch.time_value;
         got_word.status = tsp_pkg::status_type'(rsp_ch.status);
         if (time_expect.size() == 0) begin
            $error("unexpected time word: time_value %0d status %0d",
                   got_word.time_value, got_word.status);
            fail_count++;
         end else begin
            want_word = time_expect.pop_front();
            words_checked++;
            status_seen[want_word.status]++;
            if (got_word.time_value !== want_word.time_value) begin
               $error("time_value: expected %0d, got %0d",
                      want_word.time_value, got_word.time_value);
               fail_count++;
            end
            if (got_word.status !== want_word.status) begin
               $error("status: expected %0d, got %0d", want_word.status, got_word.status);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) char_backlog.push_back(s[i]);
      char_backlog.push_back(tsp_pkg::CHAR_NUL);
   endtask

   function automatic char_type pick_delimiter();
      char_type v;
      case ($urandom_range(7))
         0, 1: v = CHAR_COLON;
         2:    v = CHAR_DOT;
         3:    v = CHAR_SPACE;
         4:    v = CHAR_DASH;
         5:    v = $urandom_range(1) ? CHAR_LOWER_M : CHAR_LOWER_M - tsp_pkg::CASE_OFFSET;
         default: begin
            do v = char_type'($urandom_range(255, 1));
            while ((v >= tsp_pkg::CHAR_ZERO && v <= tsp_pkg::CHAR_NINE)
                   || v == tsp_pkg::CHAR_LOWER_A || v == tsp_pkg::CHAR_LOWER_P
                   || v == tsp_pkg::CHAR_LOWER_A - tsp_pkg::CASE_OFFSET
                   || v == tsp_pkg::CHAR_LOWER_P - tsp_pkg::CASE_OFFSET);
         end
      endcase
      return v;
   endfunction

   task automatic queue_marker();
      char_type m;
      m = $urandom_range(1) ? tsp_pkg::CHAR_LOWER_P : tsp_pkg::CHAR_LOWER_A;
      if ($urandom_range(1)) m = m - tsp_pkg::CASE_OFFSET;
      char_backlog.push_back(m);
      if ($urandom_range(2) == 0)
         char_backlog.push_back($urandom_range(1) ? CHAR_LOWER_M
                                                  : CHAR_LOWER_M - tsp_pkg::CASE_OFFSET);
   endtask

   task automatic queue_random_string();
      int shape;
      int n_nums;
      int marker_at;
      int num;
      bit wide;
      shape = $urandom_range(99);
      if (shape < 15) begin
         // raw byte noise
         repeat ($urandom_range(12, 1))
            char_backlog.push_back(char_type'($urandom_range(255, 1)));
      end else begin
         n_nums = (shape < 25) ? 5 : (shape < 33) ? 4 : $urandom_range(4);
         marker_at = (shape >= 25 && shape < 33) ? n_nums : $urandom_range(n_nums + 2);
         for (int k = 0; k < n_nums; k++) begin
            if (k == marker_at) queue_marker();
            if ($urandom_range(9) == 0) num = $urandom_range(99);
            else if (k == 0) num = (marker_at <= n_nums) ? $urandom_range(12) : $urandom_range(23);
            else num = $urandom_range(59);
            wide = (num > 9) || ($urandom_range(1) == 1);
            if (wide) char_backlog.push_back(tsp_pkg::CHAR_ZERO + char_type'(num / 10));
            char_backlog.push_back(tsp_pkg::CHAR_ZERO + char_type'(num % 10));
            // two-digit numbers may run straight into the next one
            if (k < n_nums - 1 && (!wide || $urandom_range(3) != 0))
               char_backlog.push_back(pick_delimiter());
            else if (k == n_nums - 1 && $urandom_range(3) == 0)
               char_backlog.push_back(pick_delimiter());
         end
         if (marker_at == n_nums) queue_marker();
         if (shape >= 25 && shape < 40) queue_marker();
      end
      char_backlog.push_back(tsp_pkg::CHAR_NUL);
   endtask

   task automatic queue_random_chars(input int unsigned budget);
      int unsigned start;
      start = char_backlog.size();
      while (char_backlog.size() - start < budget) queue_random_string();
   endtask

   task automatic wait_for_drain();
      while (char_backlog.size() != 0 || time_expect.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready = 1'b0;
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_text("");
      queue_text("23595999P");
      queue_text("12\377a");
      queue_text("aAp9");
      queue_text("7p");
      wait_for_drain();

      queue_random_chars(250);
      wait_for_drain();

      hold_armed = 1'b1;
      queue_random_chars(200);
      wait_for_drain();

      idle_pct = 0;
      queue_random_chars(150);
      wait_for_drain();

      idle_pct = IDLE_PCT;
      queue_random_chars(150);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("characters accepted %0d, time words checked %0d", chars_taken, words_checked);
      $display("status ok %0d, format %0d, repeat %0d, range %0d",
               status_seen[tsp_pkg::STATUS_OK], status_seen[tsp_pkg::STATUS_FORMAT],
               status_seen[tsp_pkg::STATUS_REPEAT], status_seen[tsp_pkg::STATUS_RANGE]);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
